[src/neighbor_link_cost_table_assert.svh]
// assertion macros used by the rtl datapath (nlct_dp)
`ifndef NEIGHBOR_LINK_COST_TABLE_ASSERT_SVH
`define NEIGHBOR_LINK_COST_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NLCT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nlct assertion failed");

// next-cycle implication, checked out of reset
`define NLCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nlct assertion failed");

`endif

[src/nlct_pkg.sv]
package nlct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int HISTORY_SLOTS = 10;

    localparam int ENT_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = $clog2(HISTORY_SLOTS + 1);
    localparam int HDEPTH   = TABLE_ENTRIES * HISTORY_SLOTS;
    localparam int HADDR_W  = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int COST_W   = 32;
    localparam int TIME_W   = 48;
    localparam int EXP_W    = 49;
    localparam int DIV_W    = COST_W + CNT_W;
    localparam int IN_W     = 120;
    localparam int OUT_W    = 152;

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_ERASE  = 2'd1;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_ERASED    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_FOUND     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_WRITE,
        S_READ,
        S_DS_START,
        S_DS_RUN,
        S_DL_START,
        S_DL_RUN,
        S_STORE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    search;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    write_phase;
        logic    read_phase;
        logic    div_start;
        logic    div_long;
        logic    cap_short;
        logic    store;
        logic    emit;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic       has_free;
        logic [1:0] req;
        logic       cnt_last;
        logic       cnt_end;
        logic       div_done;
        logic       out_busy;
    } stat_t;

    // seq_slot reduced modulo the slot count, 4-bit input
    function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] v);
        logic [SLOT_W-1:0] r;
        r = v;
        for (int k = 0; k < 6; k++) begin
            if (r >= SLOT_W'(HISTORY_SLOTS)) begin
                r = r - SLOT_W'(HISTORY_SLOTS);
            end
        end
        return r;
    endfunction

endpackage

[src/nlct_ram.sv]
module nlct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/nlct_ctrl.sv]
module nlct_ctrl
    import nlct_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_NOT_FOUND;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_SEARCH;
            end
            S_SEARCH: begin
                state_next = S_FINISH;
                if (stat.req == REQ_ERASE) begin
                    status_next = stat.hit ? ST_ERASED : ST_NOT_FOUND;
                end else if (stat.req == REQ_UPDATE) begin
                    if (stat.hit) begin
                        status_next = ST_UPDATED;
                        state_next  = S_WRITE;
                    end else if (stat.has_free) begin
                        status_next = ST_INSERTED;
                        state_next  = S_WRITE;
                    end else begin
                        status_next = ST_FULL;
                    end
                end else begin
                    status_next = stat.hit ? ST_FOUND : ST_NOT_FOUND;
                end
            end
            S_WRITE: begin
                if (stat.cnt_last) state_next = S_READ;
            end
            S_READ: begin
                if (stat.cnt_end) state_next = S_DS_START;
            end
            S_DS_START: state_next = S_DS_RUN;
            S_DS_RUN: begin
                if (stat.div_done) state_next = S_DL_START;
            end
            S_DL_START: state_next = S_DL_RUN;
            S_DL_RUN: begin
                if (stat.div_done) state_next = S_STORE;
            end
            S_STORE: state_next = S_FINISH;
            S_FINISH: begin
                if (!stat.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.status = status_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            S_SEARCH: begin
                cmd.search  = 1'b1;
                cmd.cnt_clr = 1'b1;
            end
            S_WRITE: begin
                cmd.write_phase = 1'b1;
                cmd.cnt_clr     = stat.cnt_last;
                cmd.cnt_inc     = !stat.cnt_last;
            end
            S_READ: begin
                cmd.read_phase = 1'b1;
                cmd.cnt_inc    = 1'b1;
            end
            S_DS_START: cmd.div_start = 1'b1;
            S_DS_RUN:   cmd.cap_short = stat.div_done;
            S_DL_START: begin
                cmd.div_start = 1'b1;
                cmd.div_long  = 1'b1;
            end
            S_DL_RUN:   cmd.div_long = 1'b1;
            S_STORE: begin
                cmd.store    = 1'b1;
                cmd.div_long = 1'b1;
            end
            S_FINISH:   cmd.emit = !stat.out_busy;
            default:    cmd = '0;
        endcase
    end

endmodule

[src/nlct_dp.sv]
module nlct_dp
    import nlct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  cmd_t             cmd,
    output stat_t            stat
);

    `include "neighbor_link_cost_table_assert.svh"

    logic [31:0]         interval_reg;
    logic [1:0]          req_reg;
    logic [31:0]         addr_reg;
    logic [COST_W-1:0]   cost_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TIME_W-1:0]   now_reg;

    logic                valid_reg  [TABLE_ENTRIES];
    logic [31:0]         key_reg    [TABLE_ENTRIES];
    logic [SLOT_W-1:0]   prev_reg   [TABLE_ENTRIES];
    logic [COST_W-1:0]   recent_reg [TABLE_ENTRIES];
    logic [COST_W-1:0]   savg_reg   [TABLE_ENTRIES];
    logic [COST_W-1:0]   lavg_reg   [TABLE_ENTRIES];
    logic [EXP_W-1:0]    exp_reg    [TABLE_ENTRIES];

    logic [ENT_W-1:0]    ent_reg;
    logic                ins_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                rd_pend_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic [COST_W-1:0]   cur_reg, v1_reg, v2_reg;
    logic [DIV_W-1:0]    lsum_reg;
    logic [CNT_W-1:0]    lcnt_reg;
    logic [DIV_W-1:0]    dvd_reg;
    logic [CNT_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [$clog2(DIV_W+1)-1:0] dcnt_reg;
    logic [COST_W-1:0]   sq_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic                hit, has_free;
    logic [ENT_W-1:0]    hit_idx, free_idx;
    logic [SLOT_W-1:0]   s1, s2;
    logic [HADDR_W-1:0]  haddr;
    logic                ram_we;
    logic [COST_W-1:0]   ram_wdata, ram_rdata;
    logic                in_range;
    logic [CNT_W:0]      rem_sh;
    logic                q_bit;
    logic [COST_W-1:0]   long_q;
    logic                show_entry;

    // associative search, lowest index wins
    always_comb begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
            if (valid_reg[e] && key_reg[e] == addr_reg) begin
                hit     = 1'b1;
                hit_idx = ENT_W'(e);
            end
            if (!valid_reg[e]) begin
                has_free = 1'b1;
                free_idx = ENT_W'(e);
            end
        end
    end

    assign s1 = (slot_reg == '0) ? SLOT_W'(HISTORY_SLOTS - 1) : slot_reg - SLOT_W'(1);
    assign s2 = (slot_reg >= SLOT_W'(2)) ? slot_reg - SLOT_W'(2)
                                         : slot_reg + SLOT_W'(HISTORY_SLOTS - 2);

    assign haddr = HADDR_W'(ent_reg * HISTORY_SLOTS) + HADDR_W'(cnt_reg);

    // gap clear covers prev+1 .. slot-1, insert clears the whole row
    assign in_range  = (cnt_reg > CNT_W'(prev_reg[ent_reg])) && (cnt_reg < CNT_W'(slot_reg));
    assign ram_we    = cmd.write_phase
                       && (cnt_reg == CNT_W'(slot_reg) || ins_reg || in_range);
    assign ram_wdata = (cnt_reg == CNT_W'(slot_reg)) ? cost_reg : '0;

    nlct_ram #(.WIDTH(COST_W), .DEPTH(HDEPTH)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (haddr),
        .wdata (ram_wdata),
        .raddr (haddr),
        .rdata (ram_rdata)
    );

    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});
    assign long_q = (lcnt_reg == '0) ? '0 : dvd_reg[COST_W-1:0];

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            for (int e = 0; e < TABLE_ENTRIES; e++) valid_reg[e] <= 1'b0;
        end else begin
            if (cfg_valid) interval_reg <= cfg_data;

            if (cmd.load) begin
                req_reg  <= s_tdata[1:0];
                addr_reg <= s_tdata[33:2];
                cost_reg <= s_tdata[65:34];
                slot_reg <= slot_mod(s_tdata[69:66]);
                now_reg  <= s_tdata[117:70];
            end

            if (cmd.search) begin
                ent_reg  <= hit ? hit_idx : free_idx;
                ins_reg  <= !hit;
                lsum_reg <= '0;
                lcnt_reg <= '0;
            end

            if (cmd.cnt_clr) cnt_reg <= '0;
            else if (cmd.cnt_inc) cnt_reg <= cnt_reg + CNT_W'(1);

            rd_pend_reg <= cmd.read_phase && (cnt_reg < CNT_W'(HISTORY_SLOTS));
            rd_idx_reg  <= cnt_reg;
            if (rd_pend_reg) begin
                if (rd_idx_reg == CNT_W'(slot_reg)) cur_reg <= ram_rdata;
                if (rd_idx_reg == CNT_W'(s1)) v1_reg <= ram_rdata;
                if (rd_idx_reg == CNT_W'(s2)) v2_reg <= ram_rdata;
                if (ram_rdata != '0) begin
                    lsum_reg <= lsum_reg + DIV_W'(ram_rdata);
                    lcnt_reg <= lcnt_reg + CNT_W'(1);
                end
            end

            // restoring divider, one quotient bit per cycle
            if (cmd.div_start) begin
                rem_reg  <= '0;
                dcnt_reg <= ($clog2(DIV_W+1))'(DIV_W);
                if (cmd.div_long) begin
                    dvd_reg <= lsum_reg;
                    dvs_reg <= lcnt_reg;
                end else begin
                    dvd_reg <= DIV_W'(cur_reg) + DIV_W'(v1_reg) + DIV_W'(v2_reg);
                    dvs_reg <= CNT_W'(1) + CNT_W'(v1_reg != '0) + CNT_W'(v2_reg != '0);
                end
            end else if (dcnt_reg != '0) begin
                rem_reg  <= q_bit ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : CNT_W'(rem_sh);
                dvd_reg  <= {dvd_reg[DIV_W-2:0], q_bit};
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.cap_short) sq_reg <= dvd_reg[COST_W-1:0];

            if (cmd.store) begin
                valid_reg[ent_reg]  <= 1'b1;
                key_reg[ent_reg]    <= addr_reg;
                prev_reg[ent_reg]   <= slot_reg;
                recent_reg[ent_reg] <= cost_reg;
                savg_reg[ent_reg]   <= sq_reg;
                lavg_reg[ent_reg]   <= long_q;
                exp_reg[ent_reg]    <= {1'b0, now_reg} + EXP_W'(interval_reg);
            end

            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                if (cmd.status == ST_ERASED) valid_reg[ent_reg] <= 1'b0;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign show_entry = (cmd.status == ST_UPDATED) || (cmd.status == ST_INSERTED)
                        || (cmd.status == ST_FOUND);

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (show_entry) begin
                out_data_reg <= {4'b0000, exp_reg[ent_reg], recent_reg[ent_reg],
                                 lavg_reg[ent_reg], savg_reg[ent_reg], cmd.status};
            end else begin
                out_data_reg <= {{(OUT_W-3){1'b0}}, cmd.status};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.hit      = hit;
    assign stat.has_free = has_free;
    assign stat.req      = req_reg;
    assign stat.cnt_last = (cnt_reg == CNT_W'(HISTORY_SLOTS - 1));
    assign stat.cnt_end  = (cnt_reg == CNT_W'(HISTORY_SLOTS));
    assign stat.div_done = (dcnt_reg == '0);
    assign stat.out_busy = out_valid_reg && !m_tready;

    `NLCT_ASSERT_SAME(a_emit_free, cmd.emit, !(out_valid_reg && !m_tready))
    `NLCT_ASSERT_SAME(a_cap_done, cmd.cap_short || cmd.store, dcnt_reg == '0)
    `NLCT_ASSERT_NEXT(a_store_valid, cmd.store, valid_reg[ent_reg])
    `NLCT_ASSERT_SAME(a_ram_range, ram_we, haddr < HADDR_W'(HDEPTH))

endmodule

[src/neighbor_link_cost_table.sv]
// neighbor link cost table
// input beats on s_tvalid/s_tready carry one request: update or insert, erase
// or lookup of a neighbor keyed by its 32-bit address. each request gives
// exactly one result beat on m_tvalid/m_tready with status and entry values.
// cfg_valid/cfg_ready write the expiry interval; write it only while idle.
// lookup, erase and table full go from accept through the search state to the
// finish state, where the result is registered. an update or insert runs a
// write sweep and a read sweep over the entry's history row in the history
// ram, then two passes of a bit-serial divider for the short and long
// averages.
// one request is worked on at a time; s_tready is high only while idle, so
// no new request is taken until the current one has reached its result.
// the result sits in an output register, so the next request is accepted
// while that result waits; a stalled receiver holds the block at its next
// result until the register frees.
// reset (aresetn low, synchronous) empties the table and clears the interval;
// s_tready and cfg_ready stay low while it is held.
module neighbor_link_cost_table
    import nlct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // req_type[1:0], neighbor_address[33:2], link_cost[65:34], seq_slot[69:66],
    // now_time[117:70], zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[2:0], short_average[34:3], long_average[66:35], last_cost[98:67],
    // expiry_time[147:99], zero fill
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    nlct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nlct_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[bench/tb_top.sv]
module tb_top;
    import nlct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] addr;
        logic [31:0] cost;
        logic [3:0]  slot;
        logic [47:0] now;
    } nbr_req_t;

    typedef struct {
        status_t     status;
        logic [31:0] short_avg;
        logic [31:0] long_avg;
        logic [31:0] last_cost;
        logic [48:0] expiry;
    } nbr_rsp_t;

    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 2000000;

    class link_table_scoreboard;
        logic [31:0] interval;
        bit          valid_q[TABLE_ENTRIES];
        logic [31:0] addr_q[TABLE_ENTRIES];
        logic [31:0] hist_q[TABLE_ENTRIES][HISTORY_SLOTS];
        int          prev_q[TABLE_ENTRIES];
        nbr_rsp_t    entry_q[TABLE_ENTRIES];
        nbr_rsp_t    pending[$];
        int          errors;

        function new();
            interval = 0;
            errors = 0;
            foreach (valid_q[e]) valid_q[e] = 0;
        endfunction

        function int find_addr(logic [31:0] a);
            foreach (valid_q[e]) if (valid_q[e] && addr_q[e] == a) return e;
            return -1;
        endfunction

        function int occupied();
            int n;
            n = 0;
            foreach (valid_q[e]) n += valid_q[e];
            return n;
        endfunction

        function void recompute_averages(int e, int s);
            int s1, s2;
            logic [63:0] sum, lsum;
            int cnt, lcnt;
            s1 = (s + HISTORY_SLOTS - 1) % HISTORY_SLOTS;
            s2 = (s + HISTORY_SLOTS - 2) % HISTORY_SLOTS;
            sum = 64'(hist_q[e][s]) + hist_q[e][s1] + hist_q[e][s2];
            cnt = 1 + (hist_q[e][s1] != 0) + (hist_q[e][s2] != 0);
            entry_q[e].short_avg = 32'(sum / cnt);
            lsum = 0;
            lcnt = 0;
            for (int j = 0; j < HISTORY_SLOTS; j++) begin
                if (hist_q[e][j] != 0) begin
                    lsum += hist_q[e][j];
                    lcnt++;
                end
            end
            entry_q[e].long_avg = lcnt ? 32'(lsum / lcnt) : 32'd0;
        endfunction

        function void note_request(nbr_req_t r);
            nbr_rsp_t x;
            int e, s;
            logic [48:0] exp_t;
            x = '{ST_NOT_FOUND, 0, 0, 0, 0};
            s = r.slot % HISTORY_SLOTS;
            exp_t = 49'(r.now) + 49'(interval);
            e = find_addr(r.addr);
            if (r.req == REQ_ERASE) begin
                if (e >= 0) begin
                    valid_q[e] = 0;
                    x.status = ST_ERASED;
                end
            end else if (r.req != REQ_UPDATE) begin
                if (e >= 0) begin
                    x = entry_q[e];
                    x.status = ST_FOUND;
                end
            end else if (e >= 0) begin
                hist_q[e][s] = r.cost;
                for (int i = prev_q[e] + 1; i < s; i++) hist_q[e][i] = 0;
                prev_q[e] = s;
                entry_q[e].last_cost = r.cost;
                entry_q[e].expiry = exp_t;
                recompute_averages(e, s);
                x = entry_q[e];
                x.status = ST_UPDATED;
            end else begin
                e = -1;
                foreach (valid_q[k]) if (!valid_q[k] && e < 0) e = k;
                if (e < 0) begin
                    x.status = ST_FULL;
                end else begin
                    valid_q[e] = 1;
                    addr_q[e] = r.addr;
                    for (int j = 0; j < HISTORY_SLOTS; j++) hist_q[e][j] = 0;
                    hist_q[e][s] = r.cost;
                    prev_q[e] = s;
                    entry_q[e] = '{ST_INSERTED, r.cost, r.cost, r.cost, exp_t};
                    x = entry_q[e];
                end
            end
            pending = {pending, x};
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            nbr_rsp_t w;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", d);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (d[2:0] !== w.status) begin
                $error("status exp %0d got %0d", w.status, d[2:0]); errors++;
            end
            if (d[34:3] !== w.short_avg) begin
                $error("short_average exp %0d got %0d", w.short_avg, d[34:3]); errors++;
            end
            if (d[66:35] !== w.long_avg) begin
                $error("long_average exp %0d got %0d", w.long_avg, d[66:35]); errors++;
            end
            if (d[98:67] !== w.last_cost) begin
                $error("last_cost exp %0d got %0d", w.last_cost, d[98:67]); errors++;
            end
            if (d[147:99] !== w.expiry) begin
                $error("expiry_time exp %0d got %0d", w.expiry, d[147:99]); errors++;
            end
        endfunction
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid = 0;
    logic             cfg_ready;
    logic [31:0]      cfg_data = '0;

    link_table_scoreboard sb = new();
    logic [31:0] addr_pool[8];
    int  cycles = 0;
    int  hold_off = 0;
    bit  stall_mode = 0;

    neighbor_link_cost_table DUT (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver stall pattern, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else if (stall_mode) begin
            m_tready <= (cycles % 7) > 2;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
        if (cycles % 500 == 0) stall_mode <= ~stall_mode;
    end

    task automatic write_interval(logic [31:0] v);
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
        sb.interval = v;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic send_request(nbr_req_t r);
        s_tdata <= {2'b0, r.now, r.slot, r.cost, r.addr, r.req};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
        @(negedge aclk);
    endtask

    task automatic send_gap();
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_cost();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic nbr_req_t rand_request();
        nbr_req_t r;
        int p;
        p = $urandom_range(0, 99);
        r.req = p < 70 ? REQ_UPDATE : p < 82 ? REQ_ERASE : p < 96 ? REQ_LOOKUP : REQ_SPARE;
        r.addr = ($urandom_range(0, 15) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
        r.cost = rand_cost();
        r.slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
        r.now = 48'({$urandom, $urandom});
        return r;
    endfunction

    initial begin
        nbr_req_t r;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        write_interval(32'hFFFF_FFFF);

        // directed: insert, in-order updates, gap clear, wrap, slots 10 and 15
        r = '{REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 48'hFFFF_FFFF_FFFF};
        send_request(r);
        r.slot = 4'd1; send_request(r);
        r.slot = 4'd5; r.cost = 32'd7; send_request(r);
        r.slot = 4'd2; r.cost = 32'd0; send_request(r);
        r.slot = 4'd15; r.cost = 32'd9; send_request(r);
        r.slot = 4'd9; send_request(r);
        r.slot = 4'd10; send_request(r);
        r = '{REQ_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0}; send_request(r);
        r.req = REQ_SPARE; send_request(r);
        r = '{REQ_UPDATE, 32'h0, 32'h0, 4'd3, 48'h0}; send_request(r);
        r.req = REQ_ERASE; send_request(r);
        send_request(r);
        r.req = REQ_LOOKUP; send_request(r);
        // fill the table, then overflow it
        for (int k = 0; k < TABLE_ENTRIES + 1; k++) begin
            r = '{REQ_UPDATE, 32'h100 + k, 32'(k + 1), 4'(k % 10), 48'(k)};
            send_request(r);
        end
        s_tvalid <= 0;
        drain();
        write_interval(32'h0);
        for (int k = 0; k < TABLE_ENTRIES + 1; k++) begin
            r = '{REQ_ERASE, 32'h100 + k, 0, 0, 0};
            send_request(r);
        end
        foreach (addr_pool[k]) addr_pool[k] = $urandom;

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) hold_off = 600;
            for (int n = 0; n < 450; n++) begin
                if ($urandom_range(0, 7) == 0) send_gap();
                r = rand_request();
                // keep the table from filling up for good
                if (sb.occupied() >= 14 && r.req == REQ_UPDATE && $urandom_range(0, 1))
                    r.req = REQ_ERASE;
                send_request(r);
            end
            s_tvalid <= 0;
            drain();
            write_interval(phase == 0 ? $urandom : phase == 1 ? 32'd1 : 32'hFFFF_FFFF);
        end

        s_tvalid <= 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+src
src/nlct_pkg.sv
src/nlct_ram.sv
src/nlct_ctrl.sv
src/nlct_dp.sv
src/neighbor_link_cost_table.sv
bench/tb_top.sv
